// File: hdl/ecal_pkg.sv
package ecal_pkg;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;
   localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [3:0]  FEBRUARY      = 4'd1;

   // constant division by reciprocal: floor(x / d) = (x * recip) >> shift
   // days: (t >> 7) / 675, hours: (s >> 4) / 225, minutes: (s >> 2) / 15, weeks: w / 7
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // shift 35
   localparam logic [13:0] HOUR_RECIP = 14'd9321;      // shift 21
   localparam logic [10:0] MIN_RECIP  = 11'd1093;      // shift 14
   localparam logic [16:0] WEEK_RECIP = 17'd74899;     // shift 19

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAY,
      ST_SOD,
      ST_HOUR,
      ST_SOH,
      ST_MIN,
      ST_SEC,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic day_calc;
      logic sod_calc;
      logic hour_calc;
      logic soh_calc;
      logic min_calc;
      logic sec_calc;
      logic year_init;
      logic year_step;
      logic month_step;
   } cmd_type;

   typedef struct packed {
      logic year_more;
      logic month_more;
   } status_type;

   function automatic logic [15:0] month_len(input logic [3:0] m, input logic leap);
      logic [15:0] len;
      case (m)
         4'd0:    len = 16'd31;
         4'd1:    len = leap ? 16'd29 : 16'd28;
         4'd2:    len = 16'd31;
         4'd3:    len = 16'd30;
         4'd4:    len = 16'd31;
         4'd5:    len = 16'd30;
         4'd6:    len = 16'd31;
         4'd7:    len = 16'd31;
         4'd8:    len = 16'd30;
         4'd9:    len = 16'd31;
         4'd10:   len = 16'd30;
         4'd11:   len = 16'd31;
         default: len = 16'd31;
      endcase
      return len;
   endfunction

endpackage

// File: hdl/ecal_ctrl.sv
module ecal_ctrl
   import ecal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            cmd.day_calc = 1'b1;
            state_in     = ST_SOD;
         end
         ST_SOD: begin
            // whole days are known, so the year count can be set up here
            cmd.sod_calc  = 1'b1;
            cmd.year_init = 1'b1;
            state_in      = ST_HOUR;
         end
         ST_HOUR: begin
            cmd.hour_calc = 1'b1;
            state_in      = ST_SOH;
         end
         ST_SOH: begin
            cmd.soh_calc = 1'b1;
            state_in     = ST_MIN;
         end
         ST_MIN: begin
            cmd.min_calc = 1'b1;
            state_in     = ST_SEC;
         end
         ST_SEC: begin
            cmd.sec_calc = 1'b1;
            state_in     = ST_YEAR;
         end
         ST_YEAR: begin
            if (status.year_more) begin
               cmd.year_step = 1'b1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (status.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// File: hdl/ecal_dp.sv
module ecal_dp
   import ecal_pkg::*;
(
   input  logic        clock,
   input  cmd_type     cmd,
   input  logic [31:0] epoch_seconds,
   output status_type  status,
   output logic [5:0]  second,
   output logic [5:0]  minute,
   output logic [4:0]  hour,
   output logic [4:0]  day_of_month,
   output logic [3:0]  month,
   output logic [11:0] year,
   output logic [2:0]  weekday
);

   logic [31:0] t_ff, t_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] sod_ff, sod_in;
   logic [15:0] wk_ff, wk_in;
   logic [12:0] wq_ff, wq_in;
   logic [11:0] soh_ff, soh_in;
   logic [15:0] rem_ff, rem_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [2:0]  weekday_ff, weekday_in;

   logic [50:0] day_prod;
   logic [16:0] day_secs;
   logic [26:0] hour_prod;
   logic [11:0] hour_secs;
   logic [20:0] min_prod;
   logic [5:0]  min_secs;
   logic [32:0] week_prod;
   logic [2:0]  week_days;
   logic        leap;
   logic [15:0] ylen;
   logic [15:0] mlen;

   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      days_ff    <= days_in;
      sod_ff     <= sod_in;
      wk_ff      <= wk_in;
      wq_ff      <= wq_in;
      soh_ff     <= soh_in;
      rem_ff     <= rem_in;
      year_ff    <= year_in;
      month_ff   <= month_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
   end

   // quotients by reciprocal multiply, remainders by multiply back and subtract
   assign day_prod  = {26'd0, t_ff[31:7]} * {25'd0, DAY_RECIP};
   assign day_secs  = days_ff * SECS_PER_DAY;
   assign hour_prod = {14'd0, sod_ff[16:4]} * {13'd0, HOUR_RECIP};
   assign hour_secs = 12'(hour_ff * SECS_PER_HOUR);
   assign min_prod  = {11'd0, soh_ff[11:2]} * {10'd0, MIN_RECIP};
   assign min_secs  = 6'(minute_ff * SECS_PER_MIN);
   assign week_prod = {17'd0, wk_ff} * {16'd0, WEEK_RECIP};
   assign week_days = 3'(wq_ff * DAYS_PER_WEEK);

   assign leap  = (year_ff[1:0] == 2'b00);
   assign ylen  = leap ? 16'd366 : 16'd365;
   assign mlen  = month_len(month_ff, leap && (month_ff == FEBRUARY));

   assign status.year_more  = (rem_ff >= ylen);
   assign status.month_more = (month_ff != LAST_MONTH) && (rem_ff >= mlen);

   always_comb begin
      t_in       = t_ff;
      days_in    = days_ff;
      sod_in     = sod_ff;
      wk_in      = wk_ff;
      wq_in      = wq_ff;
      soh_in     = soh_ff;
      rem_in     = rem_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;
      if (cmd.load) begin
         t_in = epoch_seconds;
      end
      if (cmd.day_calc) begin
         days_in = day_prod[50:35];
      end
      if (cmd.sod_calc) begin
         sod_in = t_ff[16:0] - day_secs;
         wk_in  = days_ff + EPOCH_WEEKDAY;
      end
      if (cmd.hour_calc) begin
         hour_in = hour_prod[25:21];
         wq_in   = week_prod[31:19];
      end
      if (cmd.soh_calc) begin
         soh_in     = sod_ff[11:0] - hour_secs;
         weekday_in = wk_ff[2:0] - week_days;
      end
      if (cmd.min_calc) begin
         minute_in = min_prod[19:14];
      end
      if (cmd.sec_calc) begin
         second_in = soh_ff[5:0] - min_secs;
      end
      if (cmd.year_init) begin
         rem_in   = days_ff;
         year_in  = EPOCH_YEAR;
         month_in = '0;
      end
      if (cmd.year_step) begin
         rem_in  = rem_ff - ylen;
         year_in = year_ff + 12'd1;
      end
      if (cmd.month_step) begin
         rem_in   = rem_ff - mlen;
         month_in = month_ff + 4'd1;
      end
   end

   assign second       = second_ff;
   assign minute       = minute_ff;
   assign hour         = hour_ff;
   assign day_of_month = rem_ff[4:0] + 5'd1;
   assign month        = month_ff;
   assign year         = year_ff;
   assign weekday      = weekday_ff;

endmodule

// File: hdl/epoch_seconds_to_calendar_top.sv
// after the accepting edge the controller steps through DAY, SOD, HOUR, SOH, MIN and SEC for the
// constant divisions, then YEAR once per whole year past 1970 (0..136) and MONTH once per month
// (0..11), then DONE, whose registered strobe marks the result
// throughput: one item at a time; a new item may be accepted in the cycle of the strobe
// reset: synchronous, active high, returns to idle with no strobe pending
// the receiver cannot stall: each result is shown for exactly one cycle
module epoch_seconds_to_calendar_top
   import ecal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [11:0] rsp_year,
   output logic [2:0]  rsp_weekday
);

   cmd_type    cmd;
   status_type status;

   ecal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ecal_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .epoch_seconds (req_epoch_seconds),
      .status        (status),
      .second        (rsp_second),
      .minute        (rsp_minute),
      .hour          (rsp_hour),
      .day_of_month  (rsp_day_of_month),
      .month         (rsp_month),
      .year          (rsp_year),
      .weekday       (rsp_weekday)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still working");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_month <= 4'd11) && (rsp_day_of_month != 5'd0)
                     && (rsp_weekday <= 3'd6) && (rsp_hour <= 5'd23)))
      else $error("result field out of range");

endmodule

// File: tb/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_top;
   import ecal_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 240;
   localparam int unsigned MAX_PRINTED = 30;
   localparam int unsigned LAST_DAY = 49710;
   localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30,
                                                  31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [11:0] year;
      logic [2:0]  weekday;
   } calendar_type;

   typedef struct {
      logic [31:0]  secs;
      calendar_type date;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month;
   logic [11:0] rsp_year;
   logic [2:0]  rsp_weekday;

   pending_type pending_dates [$];
   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned dates_checked = 0;
   int unsigned cycle_count = 0;
   int unsigned latest_year = 0;
   bit          no_idle = 1'b0;

   epoch_seconds_to_calendar_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_second        (rsp_second),
      .rsp_minute        (rsp_minute),
      .rsp_hour          (rsp_hour),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year),
      .rsp_weekday       (rsp_weekday)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d dates outstanding", cycle_count,
                  pending_dates.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // every year divisible by four is a leap year, 2100 included
   function automatic calendar_type decode_epoch(input logic [31:0] t);
      int unsigned  days, sod, left, yr, mon, len;
      calendar_type c;
      days = t / SECS_PER_DAY;
      sod  = t % SECS_PER_DAY;
      left = days;
      yr   = EPOCH_YEAR;
      len  = (yr % 4 == 0) ? 366 : 365;
      while (left >= len) begin
         left -= len;
         yr++;
         len = (yr % 4 == 0) ? 366 : 365;
      end
      mon = 0;
      while (mon < 11) begin
         len = MONTH_LENGTHS[mon];
         if (mon == FEBRUARY && yr % 4 == 0)
            len = 29;
         if (left < len)
            break;
         left -= len;
         mon++;
      end
      c.second       = 6'((sod % SECS_PER_HOUR) % SECS_PER_MIN);
      c.minute       = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      c.hour         = 5'(sod / SECS_PER_HOUR);
      c.day_of_month = 5'(left + 1);
      c.month        = 4'(mon);
      c.year         = 12'(yr);
      c.weekday      = 3'((days + EPOCH_WEEKDAY) % DAYS_PER_WEEK);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic compare_date(input pending_type want, input calendar_type got);
      string tag;
      tag = $sformatf("seconds %0d", want.secs);
      if (got.second !== want.date.second)
         report_mismatch($sformatf("%s second got %0d want %0d", tag, got.second,
                                   want.date.second));
      if (got.minute !== want.date.minute)
         report_mismatch($sformatf("%s minute got %0d want %0d", tag, got.minute,
                                   want.date.minute));
      if (got.hour !== want.date.hour)
         report_mismatch($sformatf("%s hour got %0d want %0d", tag, got.hour,
                                   want.date.hour));
      if (got.day_of_month !== want.date.day_of_month)
         report_mismatch($sformatf("%s day_of_month got %0d want %0d", tag,
                                   got.day_of_month, want.date.day_of_month));
      if (got.month !== want.date.month)
         report_mismatch($sformatf("%s month got %0d want %0d", tag, got.month,
                                   want.date.month));
      if (got.year !== want.date.year)
         report_mismatch($sformatf("%s year got %0d want %0d", tag, got.year,
                                   want.date.year));
      if (got.weekday !== want.date.weekday)
         report_mismatch($sformatf("%s weekday got %0d want %0d", tag, got.weekday,
                                   want.date.weekday));
   endtask

   // outputs are sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin : check_dates
      calendar_type got;
      pending_type  want;
      if (!reset && rsp_valid) begin
         got = '{rsp_second, rsp_minute, rsp_hour, rsp_day_of_month, rsp_month, rsp_year,
                 rsp_weekday};
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_dates.pop_front();
            compare_date(want, got);
            dates_checked++;
         end
      end
   end

   // called at a rising edge; leaves start high after the accepting edge
   task automatic send_seconds(input logic [31:0] t);
      int unsigned gap;
      bit          after_idle;
      pending_type p;
      gap        = no_idle ? 0 : $urandom_range(0, 6);
      after_idle = no_idle ? 1'b0 : ($urandom_range(0, 2) == 0);
      if (after_idle) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
      end else if (gap > 0) begin
         start <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      start             <= 1'b1;
      req_epoch_seconds <= t;
      do @(posedge clock); while (busy);
      p.secs = t;
      p.date = decode_epoch(t);
      pending_dates.push_back(p);
      items_sent++;
      if (p.date.year > latest_year)
         latest_year = p.date.year;
   endtask

   task automatic test_directed_edges();
      logic [31:0] values [$];
      values = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                 32'd31535999, 32'd31536000,      // end of 1970, start of 1971
                 32'd68169599, 32'd68169600,      // 1972-02-28 last second, leap day
                 32'd68255999, 32'd68256000,      // end of leap day, march 1972
                 32'd94694399, 32'd94694400,      // end of the 366-day year
                 32'd951782400,                   // 2000 leap day
                 32'd4107542400, 32'd4107628800,  // 2100 counted as leap
                 32'd4291747200,                  // 2105-12-31, as 2100 is counted as leap
                 32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF};
      foreach (values[i])
         send_seconds(values[i]);
   endtask

   task automatic test_random_full_range(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         send_seconds($urandom);
      end
   endtask

   // items at or next to day, month and year boundaries, or at a random second of such a day
   task automatic test_random_day_edges(input int unsigned count);
      longint      v;
      int unsigned day, yr, mon;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0) begin
            day = $urandom_range(0, LAST_DAY);
         end else begin
            yr  = $urandom_range(EPOCH_YEAR, 2106);
            mon = (yr == 2106) ? $urandom_range(0, 1) : $urandom_range(0, 11);
            day = 0;
            for (int unsigned y = EPOCH_YEAR; y < yr; y++)
               day += (y % 4 == 0) ? 366 : 365;
            for (int unsigned m = 0; m < mon; m++)
               day += (m == FEBRUARY && yr % 4 == 0) ? 29 : MONTH_LENGTHS[m];
         end
         v = longint'(day) * SECS_PER_DAY;
         case ($urandom_range(0, 3))
            0: v = v;
            1: v = v - 1;
            2: v = v + 86399;
            default: v = v + $urandom_range(0, 86399);
         endcase
         if (v < 0)
            v = 0;
         if (v > longint'(32'hFFFFFFFF))
            v = longint'(32'hFFFFFFFF);
         send_seconds(v[31:0]);
      end
   endtask

   task automatic test_random_extremes(input int unsigned count);
      logic [31:0] t;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         t = $urandom_range(0, 32'h000FFFFF);
         if ($urandom_range(0, 1) == 0)
            t = 32'hFFFFFFFF - t;
         send_seconds(t);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_random_full_range(500);
      test_random_day_edges(400);
      test_random_extremes(200);
      start <= 1'b0;
      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d items, checked %0d dates up to year %0d", items_sent, dates_checked,
               latest_year);
      $display("covered unit, day, month and year boundaries plus random full-range seconds");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
